@@ rtl/generational_slot_table_core_defines.svh @@
// Assertion macros shared by the checker of the generational slot table.
// No dependencies; include by bare file name.
`ifndef GENERATIONAL_SLOT_TABLE_CORE_DEFINES_SVH
`define GENERATIONAL_SLOT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("generational slot table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("generational slot table check failed");

`endif

@@ rtl/gst_pkg.sv @@
// Shared types, codes and helpers of the generational slot table.
// No dependencies; used by the core, the RAM wrapper users and the checker.
`default_nettype none

package gst_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int GEN_W    = 32;
    localparam int TAG_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STALE     = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  target_tag;
        logic [7:0]        slot_index;
        logic [GEN_W-1:0]  slot_generation;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          out_index;
        logic [GEN_W-1:0]    out_generation;
        logic [TAG_W-1:0]    out_target;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_REUSE
    } t_state;

    // Next generation, skipping zero on wrap.
    function automatic logic [GEN_W-1:0] gen_inc(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] ng;
        ng = g + GEN_W'(1);
        if (ng == '0) begin
            ng = GEN_W'(1);
        end
        return ng;
    endfunction

    // Zero is never handed out: map it to one.
    function automatic logic [GEN_W-1:0] gen_nz(input logic [GEN_W-1:0] g);
        return (g == '0) ? GEN_W'(1) : g;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gst_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module gst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/generational_slot_table_core.sv @@
// Top level of the generational slot table: sequencer, counters, occupied bits.
// Depends on gst_pkg and gst_ram (generation, target and free-stack memories).
//
//   channel   direction  handshake                     payload
//   request   in         i_req_valid / o_req_stall     i_req  (gst_pkg::t_req)
//   response  out        o_rsp_valid / i_rsp_stall     o_rsp  (gst_pkg::t_rsp)
//   config    in         i_cfg_we                      i_cfg_wdata (bus_alive)
//
// One request at a time: accept in S_IDLE, then check and write back in S_LOOK; an
// allocate that reuses a freed index adds S_REUSE (free-stack read at accept, then
// generation read in S_LOOK); the response register loads when S_LOOK or S_REUSE commits.
// Reset is synchronous; occupied bits clear at once, no clearing pass.
// A stalled response holds in the output register; the next request is
// accepted meanwhile and waits for the register before it writes back.
`default_nettype none

module generational_slot_table_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire gst_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output gst_pkg::t_rsp      o_rsp,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata
);

    gst_pkg::t_state r_state, n_state;
    gst_pkg::t_req   r_req;
    gst_pkg::t_rsp   r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic            r_bus_alive;

    logic [gst_pkg::SLOTS-1:0] r_occupied;
    logic [gst_pkg::CNT_W-1:0] r_free_count, n_free_count;
    logic [gst_pkg::CNT_W-1:0] r_fresh, n_fresh;
    logic [gst_pkg::GEN_W-1:0] r_global, n_global;
    logic [gst_pkg::IDX_W-1:0] r_slot, n_slot;

    logic                      occ_we, occ_val;
    logic [gst_pkg::IDX_W-1:0] occ_addr;

    logic                      gen_we, gen_re;
    logic [gst_pkg::IDX_W-1:0] gen_waddr, gen_raddr;
    logic [gst_pkg::GEN_W-1:0] gen_wdata, gen_rdata;

    logic                      tgt_we, tgt_re;
    logic [gst_pkg::IDX_W-1:0] tgt_waddr;
    logic [gst_pkg::TAG_W-1:0] tgt_rdata;

    logic                      stk_we, stk_re;
    logic [gst_pkg::IDX_W-1:0] stk_waddr, stk_raddr;
    logic [gst_pkg::IDX_W-1:0] stk_rdata;

    logic                      out_free, commit;
    logic [gst_pkg::CNT_W-1:0] stk_top;
    logic [gst_pkg::GEN_W-1:0] g_take;

    gst_ram #(.WIDTH(gst_pkg::GEN_W), .DEPTH(gst_pkg::SLOTS)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_re    (gen_re),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    gst_ram #(.WIDTH(gst_pkg::TAG_W), .DEPTH(gst_pkg::SLOTS)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (tgt_we),
        .i_waddr (tgt_waddr),
        .i_wdata (r_req.target_tag),
        .i_re    (tgt_re),
        .i_raddr (i_req.slot_index),
        .o_rdata (tgt_rdata)
    );

    gst_ram #(.WIDTH(gst_pkg::IDX_W), .DEPTH(gst_pkg::SLOTS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_req.slot_index),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_req_stall = (r_state != gst_pkg::S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    assign out_free = !r_out_valid || !i_rsp_stall;
    assign stk_top  = r_free_count - gst_pkg::CNT_W'(1);
    assign stk_raddr = stk_top[gst_pkg::IDX_W-1:0];
    // Global counter may sit at zero after a wrap: take one instead.
    assign g_take   = gst_pkg::gen_nz(r_global);

    always_comb begin
        n_state      = r_state;
        n_free_count = r_free_count;
        n_fresh      = r_fresh;
        n_global     = r_global;
        n_slot       = r_slot;
        n_out        = '0;
        commit       = 1'b0;
        occ_we       = 1'b0;
        occ_val      = 1'b0;
        occ_addr     = r_req.slot_index;
        gen_we       = 1'b0;
        gen_waddr    = r_req.slot_index;
        gen_wdata    = '0;
        gen_re       = 1'b0;
        gen_raddr    = i_req.slot_index;
        tgt_we       = 1'b0;
        tgt_waddr    = r_req.slot_index;
        tgt_re       = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = r_free_count[gst_pkg::IDX_W-1:0];
        stk_re       = 1'b0;

        unique case (r_state)
            gst_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    gen_re  = 1'b1;
                    tgt_re  = 1'b1;
                    stk_re  = 1'b1;
                    n_state = gst_pkg::S_LOOK;
                end
            end

            gst_pkg::S_LOOK: begin
                commit = out_free;
                if (r_req.func == gst_pkg::FUNC_ALLOC) begin
                    if (r_req.target_tag == '0) begin
                        n_out.status = gst_pkg::ST_INVALID;
                    end else if (!r_bus_alive) begin
                        n_out.status = gst_pkg::ST_DISABLED;
                    end else if (r_free_count != '0) begin
                        // Reuse: fetch the remembered generation of the stack top.
                        commit    = 1'b0;
                        gen_re    = 1'b1;
                        gen_raddr = stk_rdata;
                        n_slot    = stk_rdata;
                        n_state   = gst_pkg::S_REUSE;
                    end else if (r_fresh < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                        n_out.status         = gst_pkg::ST_OK;
                        n_out.out_index      = r_fresh[gst_pkg::IDX_W-1:0];
                        n_out.out_generation = g_take;
                        occ_addr  = r_fresh[gst_pkg::IDX_W-1:0];
                        gen_waddr = r_fresh[gst_pkg::IDX_W-1:0];
                        tgt_waddr = r_fresh[gst_pkg::IDX_W-1:0];
                        gen_wdata = g_take;
                        occ_val   = 1'b1;
                        occ_we    = commit;
                        gen_we    = commit;
                        tgt_we    = commit;
                        if (commit) begin
                            n_fresh  = r_fresh + gst_pkg::CNT_W'(1);
                            n_global = g_take + gst_pkg::GEN_W'(1);
                        end
                    end else begin
                        n_out.status = gst_pkg::ST_FULL;
                    end
                end else if (r_req.func == gst_pkg::FUNC_RELEASE ||
                             r_req.func == gst_pkg::FUNC_LOOKUP) begin
                    // Index field spans exactly the table depth: never out of range.
                    if (r_req.slot_generation == '0) begin
                        n_out.status = gst_pkg::ST_INVALID;
                    end else if (!r_bus_alive) begin
                        n_out.status = gst_pkg::ST_DISABLED;
                    end else if (!r_occupied[r_req.slot_index]) begin
                        n_out.status = gst_pkg::ST_NOT_FOUND;
                    end else if (gen_rdata != r_req.slot_generation) begin
                        n_out.status = gst_pkg::ST_STALE;
                    end else if (r_req.func == gst_pkg::FUNC_LOOKUP) begin
                        n_out.status     = gst_pkg::ST_OK;
                        n_out.out_target = tgt_rdata;
                    end else begin
                        n_out.status = gst_pkg::ST_OK;
                        gen_wdata    = gst_pkg::gen_inc(gen_rdata);
                        gen_we       = commit;
                        occ_val      = 1'b0;
                        occ_we       = commit;
                        if (r_free_count < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                            stk_we = commit;
                            if (commit) begin
                                n_free_count = r_free_count + gst_pkg::CNT_W'(1);
                            end
                        end
                    end
                end else begin
                    n_out.status = gst_pkg::ST_INVALID;
                end
                if (commit) begin
                    n_state = gst_pkg::S_IDLE;
                end
            end

            gst_pkg::S_REUSE: begin
                commit               = out_free;
                n_out.status         = gst_pkg::ST_OK;
                n_out.out_index      = r_slot;
                n_out.out_generation = gst_pkg::gen_nz(gen_rdata);
                occ_addr  = r_slot;
                gen_waddr = r_slot;
                tgt_waddr = r_slot;
                gen_wdata = gst_pkg::gen_nz(gen_rdata);
                occ_val   = 1'b1;
                occ_we    = commit;
                gen_we    = commit;
                tgt_we    = commit;
                if (commit) begin
                    n_free_count = stk_top;
                    n_state      = gst_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = gst_pkg::S_IDLE;
            end
        endcase

        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gst_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_bus_alive  <= 1'b1;
            r_occupied   <= '0;
            r_free_count <= '0;
            r_fresh      <= '0;
            r_global     <= gst_pkg::GEN_W'(1);
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_free_count <= n_free_count;
            r_fresh      <= n_fresh;
            r_global     <= n_global;
            if (i_cfg_we) begin
                r_bus_alive <= i_cfg_wdata;
            end
            if (occ_we) begin
                r_occupied[occ_addr] <= occ_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gst_pkg::S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (commit) begin
            r_out <= n_out;
        end
        r_slot <= n_slot;
    end

endmodule

`default_nettype wire

@@ rtl/gst_checker.sv @@
// Port-level checks of the generational slot table, bound to the top level.
// Depends on gst_pkg and generational_slot_table_core_defines.svh.
`default_nettype none

`include "generational_slot_table_core_defines.svh"

module gst_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          o_req_stall,
    input wire gst_pkg::t_req i_req,
    input wire logic          o_rsp_valid,
    input wire logic          i_rsp_stall,
    input wire gst_pkg::t_rsp o_rsp
);

    logic req_take;
    logic rsp_fail;

    assign req_take = i_req_valid && !o_req_stall;
    assign rsp_fail = o_rsp_valid && (o_rsp.status != gst_pkg::ST_OK);

    // One request in flight: taking a request closes the input.
    `GST_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, req_take, o_req_stall)

    // A new response only comes out of a busy sequencer.
    `GST_ASSERT_IMP(a_rsp_from_busy, i_clk, i_rst_n, $rose(o_rsp_valid), $past(o_req_stall))

    // A stalled response stays put.
    `GST_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp))

    // A failed request hands out no handle and no target.
    `GST_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, rsp_fail, o_rsp.out_index == '0 && o_rsp.out_generation == '0 && o_rsp.out_target == '0)

endmodule

bind generational_slot_table_core gst_checker u_gst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for generational_slot_table_core: handle allocate, release and lookup.
// Depends on gst_pkg; responses are checked in order against a handle-table predictor.

module tb;

    localparam logic [gst_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    class slot_table_scoreboard;
        bit                        alive;
        bit                        busy [gst_pkg::SLOTS];
        logic [gst_pkg::GEN_W-1:0] gen_mem [gst_pkg::SLOTS];
        logic [gst_pkg::TAG_W-1:0] tag_mem [gst_pkg::SLOTS];
        logic [gst_pkg::IDX_W-1:0] free_lifo [gst_pkg::SLOTS];
        int                        free_depth;
        int                        fresh_next;
        logic [gst_pkg::GEN_W-1:0] gen_counter;
        gst_pkg::t_rsp             awaited_rsp [$];
        int                        errors;
        int                        requests;
        int                        reuses;
        int                        status_hits [8];

        function new();
            alive = 1'b1;
            gen_counter = gst_pkg::GEN_W'(1);
        endfunction

        // Advance the table by one request and return the response it owes.
        function gst_pkg::t_rsp serve(gst_pkg::t_req r);
            gst_pkg::t_rsp             a;
            logic [gst_pkg::IDX_W-1:0] s;
            logic [gst_pkg::GEN_W-1:0] g;
            bit                        got;
            a = '0;
            a.status = gst_pkg::ST_OK;
            s = r.slot_index;
            case (r.func)
                gst_pkg::FUNC_ALLOC: begin
                    got = 1'b1;
                    if (r.target_tag == '0) begin
                        a.status = gst_pkg::ST_INVALID;
                        got = 1'b0;
                    end else if (!alive) begin
                        a.status = gst_pkg::ST_DISABLED;
                        got = 1'b0;
                    end else if (free_depth > 0) begin
                        free_depth--;
                        s = free_lifo[free_depth];
                        g = gen_mem[s];
                        if (g == '0) g = gst_pkg::GEN_W'(1);
                        reuses++;
                    end else if (fresh_next < gst_pkg::SLOTS) begin
                        s = gst_pkg::IDX_W'(fresh_next);
                        fresh_next++;
                        g = gen_counter;
                        gen_counter = g + gst_pkg::GEN_W'(1);
                        // skip generation zero on wrap
                        if (g == '0) begin
                            g = gen_counter;
                            gen_counter = g + gst_pkg::GEN_W'(1);
                        end
                    end else begin
                        a.status = gst_pkg::ST_FULL;
                        got = 1'b0;
                    end
                    if (got) begin
                        busy[s] = 1'b1;
                        gen_mem[s] = g;
                        tag_mem[s] = r.target_tag;
                        a.out_index = s;
                        a.out_generation = g;
                    end
                end
                gst_pkg::FUNC_RELEASE, gst_pkg::FUNC_LOOKUP: begin
                    if (r.slot_generation == '0) begin
                        a.status = gst_pkg::ST_INVALID;
                    end else if (!alive) begin
                        a.status = gst_pkg::ST_DISABLED;
                    end else if (!busy[s]) begin
                        a.status = gst_pkg::ST_NOT_FOUND;
                    end else if (gen_mem[s] != r.slot_generation) begin
                        a.status = gst_pkg::ST_STALE;
                    end else if (r.func == gst_pkg::FUNC_LOOKUP) begin
                        a.out_target = tag_mem[s];
                    end else begin
                        g = gen_mem[s] + gst_pkg::GEN_W'(1);
                        if (g == '0) g = gst_pkg::GEN_W'(1);
                        gen_mem[s] = g;
                        busy[s] = 1'b0;
                        free_lifo[free_depth] = s;
                        free_depth++;
                    end
                end
                default: a.status = gst_pkg::ST_INVALID;
            endcase
            status_hits[a.status]++;
            return a;
        endfunction

        function void note_request(gst_pkg::t_req r);
            gst_pkg::t_rsp owed;
            requests++;
            owed = serve(r);
            awaited_rsp = {awaited_rsp, owed};
        endfunction

        function void flag(string what, gst_pkg::t_rsp want, gst_pkg::t_rsp got);
            errors++;
            if (errors <= 10)
                $display({"mismatch %0d (%s): expected st=%0d idx=%0d gen=%h tgt=%h,",
                          " got st=%0d idx=%0d gen=%h tgt=%h"},
                         errors, what, want.status, want.out_index, want.out_generation,
                         want.out_target, got.status, got.out_index, got.out_generation,
                         got.out_target);
        endfunction

        function void check_response(gst_pkg::t_rsp got);
            gst_pkg::t_rsp want;
            if (awaited_rsp.size() == 0) begin
                flag("response with no request pending", '0, got);
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.out_index !== want.out_index ||
                got.out_generation !== want.out_generation ||
                got.out_target !== want.out_target)
                flag("field differs", want, got);
        endfunction

        // Pick a random live handle, if any slot is occupied.
        function bit live_handle(output logic [gst_pkg::IDX_W-1:0] idx,
                                 output logic [gst_pkg::GEN_W-1:0] g);
            int start;
            int s;
            start = $urandom_range(gst_pkg::SLOTS - 1);
            for (int k = 0; k < gst_pkg::SLOTS; k++) begin
                s = (start + k) % gst_pkg::SLOTS;
                if (busy[s]) begin
                    idx = gst_pkg::IDX_W'(s);
                    g = gen_mem[s];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          i_req_valid = 1'b0;
    logic          o_req_stall;
    gst_pkg::t_req i_req = '0;
    logic          o_rsp_valid;
    logic          i_rsp_stall = 1'b0;
    gst_pkg::t_rsp o_rsp;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_wdata = 1'b0;

    slot_table_scoreboard sb = new();

    int src_idle_pct = 24;
    int sink_stall_pct = 24;
    bit rsp_hold_arm = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    generational_slot_table_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Response side: check accepted responses, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) sb.check_response(o_rsp);
            if (rsp_hold_arm) begin
                hold_left = HOLD_CYCLES;
                rsp_hold_arm = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_stall <= 1'b1;
            end else begin
                i_rsp_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, sb.awaited_rsp.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic gst_pkg::t_req make_req(logic [gst_pkg::FUNC_W-1:0] f,
                                               logic [gst_pkg::TAG_W-1:0] tag,
                                               logic [7:0] idx,
                                               logic [gst_pkg::GEN_W-1:0] g);
        gst_pkg::t_req r;
        r.func = f;
        r.target_tag = tag;
        r.slot_index = idx;
        r.slot_generation = g;
        return r;
    endfunction

    // Mostly well-formed handle traffic; the remainder is stale, bogus or malformed.
    function automatic gst_pkg::t_req draw_request(int alloc_pct, int release_pct,
                                                   int lookup_pct);
        gst_pkg::t_req             r;
        int                        roll;
        logic [gst_pkg::IDX_W-1:0] idx;
        logic [gst_pkg::GEN_W-1:0] g;
        r.func = gst_pkg::FUNC_ALLOC;
        r.target_tag = $urandom;
        r.slot_index = 8'($urandom);
        r.slot_generation = $urandom;
        roll = $urandom_range(99);
        if (roll < alloc_pct) begin
            if (r.target_tag == '0) r.target_tag = gst_pkg::TAG_W'(1);
        end else if (roll < alloc_pct + release_pct + lookup_pct &&
                     sb.live_handle(idx, g)) begin
            r.func = (roll < alloc_pct + release_pct) ? gst_pkg::FUNC_RELEASE
                                                      : gst_pkg::FUNC_LOOKUP;
            r.slot_index = idx;
            r.slot_generation = g;
        end else begin
            r.func = $urandom_range(1) ? gst_pkg::FUNC_RELEASE : gst_pkg::FUNC_LOOKUP;
            case ($urandom_range(3))
                0: r.func = FUNC_UNUSED;
                1: begin
                    if (sb.live_handle(idx, g)) begin
                        r.slot_index = idx;
                        r.slot_generation =
                            g ^ (gst_pkg::GEN_W'(1) << $urandom_range(gst_pkg::GEN_W - 1));
                    end
                end
                2: ;
                default: begin
                    r.slot_generation = '0;
                    if ($urandom_range(1)) begin
                        r.func = gst_pkg::FUNC_ALLOC;
                        r.target_tag = '0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input gst_pkg::t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic run_phase(int count, int alloc_pct, int release_pct, int lookup_pct);
        for (int n = 0; n < count; n++)
            send_request(draw_request(alloc_pct, release_pct, lookup_pct));
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_bus_alive(bit v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.alive = v;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_bus_alive(1'b1);

        // fresh slots 0 and 1, then lookup/release corner cases and reuse of slot 1
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'h0000_0001, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'h0000_0000, 8'd3, 32'd7));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd0, 32'd1));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd0, 32'hFFFF_FFFF));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'hFF, 32'd1));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd1, 32'd0));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd1, 32'd2));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd1, 32'd2));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd1, 32'd2));
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'hA5A5_5A5A, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd1, 32'd2));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd1, 32'd3));
        send_request(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_req(FUNC_UNUSED, 32'd0, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd0, 32'd1));

        write_bus_alive(1'b0);
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'd5, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'd0, 8'd0, 32'd1));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd1, 32'd0));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'd1, 32'd3));
        send_request(make_req(gst_pkg::FUNC_RELEASE, 32'd0, 8'd1, 32'd3));
        send_request(make_req(FUNC_UNUSED, 32'd9, 8'd1, 32'd3));

        write_bus_alive(1'b1);
        send_request(make_req(gst_pkg::FUNC_ALLOC, 32'h8000_0000, 8'd0, 32'd0));
        send_request(make_req(gst_pkg::FUNC_LOOKUP, 32'd0, 8'hFF, 32'hFFFF_FFFF));

        // mixed traffic: a stretch with no idling, then a long response hold-off
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_phase(150, 40, 25, 25);
        src_idle_pct = 24;
        sink_stall_pct = 24;
        run_phase(100, 40, 25, 25);
        rsp_hold_arm = 1'b1;
        run_phase(150, 40, 25, 25);

        // hold the sender until every response is in, then fill the table past full
        wait_drained();
        run_phase(360, 75, 8, 10);

        write_bus_alive(1'b0);
        run_phase(60, 30, 25, 25);

        write_bus_alive(1'b1);
        run_phase(300, 15, 50, 25);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests, %0d slot reuses, bus enable switched off and on",
                 sb.requests, sb.reuses);
        $display("results: ok %0d, invalid %0d, disabled %0d, full %0d, not found %0d, stale %0d",
                 sb.status_hits[gst_pkg::ST_OK], sb.status_hits[gst_pkg::ST_INVALID],
                 sb.status_hits[gst_pkg::ST_DISABLED], sb.status_hits[gst_pkg::ST_FULL],
                 sb.status_hits[gst_pkg::ST_NOT_FOUND], sb.status_hits[gst_pkg::ST_STALE]);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gst_pkg.sv
rtl/gst_ram.sv
rtl/generational_slot_table_core.sv
rtl/gst_checker.sv
tb/tb.sv
